[hdl/rhpc_pkg.sv]
// Shared types and constants for the rectangle head placement classifier.
`timescale 1ns / 1ps

package rhpc_pkg;

  // Fixed field widths of the item and register interfaces.
  localparam int unsigned SPAN_W     = 15;
  localparam int unsigned AREA_W     = 2 * SPAN_W;
  localparam int unsigned HIDX_IN_W  = 3;
  localparam int unsigned CHOSEN_W   = 3;
  localparam int unsigned PRIM_W     = 3;
  localparam int unsigned HCNT_W     = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 15;

  // Register reset values.
  localparam logic [SPAN_W-1:0] SCREEN_W_RST  = 15'd1920;
  localparam logic [SPAN_W-1:0] SCREEN_H_RST  = 15'd1080;
  localparam logic [PRIM_W-1:0] PRIMARY_RST   = 3'd0;
  localparam logic [HCNT_W-1:0] HEAD_CNT_RST  = 4'd0;

  // Drain counter value at which the accumulator has settled after the last table read.
  localparam logic [1:0] DRAIN_LAST = 2'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_PRIMARY_HEAD  = 2'd2,
    CFG_HEAD_COUNT    = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_LOAD     = 1'b0,
    OP_CLASSIFY = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } ctrl_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic start;
    logic issue;
    logic finish;
  } rhpc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic walk_last;
  } rhpc_status_t;

endpackage

[hdl/rhpc_ctrl.sv]
// Controller state machine: input and output handshakes and the head walk sequence.
`timescale 1ns / 1ps

module rhpc_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  opcode_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  input  rhpc_pkg::rhpc_status_t status_i,
  output rhpc_pkg::rhpc_cmd_t    cmd_o
);
  import rhpc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic [1:0]  drain_q, drain_d;

  // State, drain counter and output valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      drain_q     <= 2'd0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      drain_q     <= drain_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    drain_d     = 2'd0;
    out_valid_d = out_valid_q & out_stall_i;
    cmd_o       = '0;
    in_stall_o  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (opcode_i == OP_LOAD) begin
            cmd_o.load = 1'b1;
          end else begin
            cmd_o.start = 1'b1;
            state_d     = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        cmd_o.issue = 1'b1;
        if (status_i.walk_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drain_q == DRAIN_LAST) begin
          state_d = ST_FINISH;
        end else begin
          drain_d = drain_q + 2'd1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // A result is only written into the output register when it is free.
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> (!out_valid_q || !out_stall_i))
    else $error("result written over an untaken beat");

  // A new output beat only appears after a finished classify.
  a_valid_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.finish))
    else $error("output valid rose without a finish");

  // The drain counter rests at zero outside the drain phase.
  a_drain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_DRAIN) |-> (drain_q == 2'd0))
    else $error("drain counter active outside drain");

  // A classify beat always starts a walk.
  a_start_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.start |=> (state_q == ST_WALK))
    else $error("classify beat did not start a walk");
`endif

endmodule

[hdl/rhpc_dp.sv]
// Datapath: configuration registers, head table, overlap pipeline and result register.
`timescale 1ns / 1ps

module rhpc_dp #(
  parameter int unsigned MAX_HEADS  = 8,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [rhpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rhpc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [rhpc_pkg::HIDX_IN_W-1:0]      head_index_i,
  input  logic signed [COORD_BITS-1:0]        rect_x_i,
  input  logic signed [COORD_BITS-1:0]        rect_y_i,
  input  logic [rhpc_pkg::SPAN_W-1:0]         rect_width_i,
  input  logic [rhpc_pkg::SPAN_W-1:0]         rect_height_i,
  input  logic signed [COORD_BITS-1:0]        pointer_x_i,
  input  logic signed [COORD_BITS-1:0]        pointer_y_i,
  input  logic                                pointer_valid_i,
  input  rhpc_pkg::rhpc_cmd_t                 cmd_i,
  output rhpc_pkg::rhpc_status_t              status_o,
  output logic [rhpc_pkg::CHOSEN_W-1:0]       chosen_head_o,
  output logic                                dead_flag_o,
  output logic                                partial_flag_o,
  output logic                                multiple_flag_o
);
  import rhpc_pkg::*;

  localparam int unsigned IDX_W = (MAX_HEADS > 1) ? $clog2(MAX_HEADS) : 1;
  localparam int unsigned CNT_W = HCNT_W + 1;
  localparam int unsigned EW    = ((COORD_BITS > SPAN_W) ? COORD_BITS : SPAN_W) + 2;
  localparam int unsigned TOT_W = AREA_W + $clog2(MAX_HEADS + 1);

  // Configuration registers.
  logic [SPAN_W-1:0] screen_w_q, screen_h_q;
  logic [PRIM_W-1:0] primary_q;
  logic [HCNT_W-1:0] head_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_w_q <= SCREEN_W_RST;
      screen_h_q <= SCREEN_H_RST;
      primary_q  <= PRIMARY_RST;
      head_cnt_q <= HEAD_CNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_SCREEN_WIDTH:  screen_w_q <= cfg_data_i[SPAN_W-1:0];
        CFG_SCREEN_HEIGHT: screen_h_q <= cfg_data_i[SPAN_W-1:0];
        CFG_PRIMARY_HEAD:  primary_q  <= cfg_data_i[PRIM_W-1:0];
        CFG_HEAD_COUNT:    head_cnt_q <= cfg_data_i[HCNT_W-1:0];
        default:           head_cnt_q <= head_cnt_q;
      endcase
    end
  end

  // Head table; loads beyond the table are dropped.
  logic signed [COORD_BITS-1:0] tbl_left [MAX_HEADS];
  logic signed [COORD_BITS-1:0] tbl_top  [MAX_HEADS];
  logic [SPAN_W-1:0]            tbl_sx   [MAX_HEADS];
  logic [SPAN_W-1:0]            tbl_sy   [MAX_HEADS];
  logic [IDX_W+HIDX_IN_W-1:0]   ld_wide;
  logic [IDX_W-1:0]             ld_addr;
  logic                         ld_ok;

  assign ld_wide = {{IDX_W{1'b0}}, head_index_i};
  assign ld_addr = ld_wide[IDX_W-1:0];
  assign ld_ok   = (ld_wide < (IDX_W + HIDX_IN_W)'(MAX_HEADS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && ld_ok) begin
      tbl_left[ld_addr] <= rect_x_i;
      tbl_top[ld_addr]  <= rect_y_i;
      tbl_sx[ld_addr]   <= rect_width_i;
      tbl_sy[ld_addr]   <= rect_height_i;
    end
  end

  // Effective head count and walk bounds.
  logic [CNT_W-1:0] cnt_raw, cnt_eff, cnt_m1;
  assign cnt_raw = {1'b0, head_cnt_q};
  assign cnt_eff = (cnt_raw > CNT_W'(MAX_HEADS)) ? CNT_W'(MAX_HEADS) : cnt_raw;
  assign cnt_m1  = cnt_eff - CNT_W'(1);

  // Item registers, latched when a classify beat is accepted.
  logic signed [COORD_BITS-1:0] rx_q, ry_q, px_q, py_q;
  logic [SPAN_W-1:0]            rw_q, rh_q;
  logic                         pv_q, screen_q;
  logic [IDX_W-1:0]             last_idx_q, head_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      rx_q       <= rect_x_i;
      ry_q       <= rect_y_i;
      rw_q       <= rect_width_i;
      rh_q       <= rect_height_i;
      px_q       <= pointer_x_i;
      py_q       <= pointer_y_i;
      pv_q       <= pointer_valid_i;
      screen_q   <= (cnt_eff <= CNT_W'(1));
      last_idx_q <= (cnt_eff <= CNT_W'(1)) ? '0 : cnt_m1[IDX_W-1:0];
      head_idx_q <= '0;
    end else if (cmd_i.issue) begin
      head_idx_q <= head_idx_q + IDX_W'(1);
    end
  end

  assign status_o.walk_last = (head_idx_q == last_idx_q);

  // Pipeline valid bits.
  logic v0_q, v1_q, v2_q, v3_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.issue;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Stage 0: read one head, or the full screen with one head or none.
  logic signed [COORD_BITS-1:0] h_left_q, h_top_q;
  logic [SPAN_W-1:0]            h_sx_q, h_sy_q;
  logic [IDX_W-1:0]             s0_idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      s0_idx_q <= head_idx_q;
      if (screen_q) begin
        h_left_q <= '0;
        h_top_q  <= '0;
        h_sx_q   <= screen_w_q;
        h_sy_q   <= screen_h_q;
      end else begin
        h_left_q <= tbl_left[head_idx_q];
        h_top_q  <= tbl_top[head_idx_q];
        h_sx_q   <= tbl_sx[head_idx_q];
        h_sy_q   <= tbl_sy[head_idx_q];
      end
    end
  end

  // Stage 1: edge bounds of the overlap and the pointer test.
  logic signed [EW-1:0] rx_e, ry_e, rw_e, rh_e, hx_e, hy_e, hw_e, hh_e, px_e, py_e;
  logic signed [EW-1:0] ea_x, eb_x, ea_y, eb_y, dx, dy;
  logic signed [EW-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q;
  logic                 in_ptr_s1;
  logic                 ptr1_q;
  logic [IDX_W-1:0]     s1_idx_q;

  assign rx_e = {{(EW-COORD_BITS){rx_q[COORD_BITS-1]}}, rx_q};
  assign ry_e = {{(EW-COORD_BITS){ry_q[COORD_BITS-1]}}, ry_q};
  assign px_e = {{(EW-COORD_BITS){px_q[COORD_BITS-1]}}, px_q};
  assign py_e = {{(EW-COORD_BITS){py_q[COORD_BITS-1]}}, py_q};
  assign hx_e = {{(EW-COORD_BITS){h_left_q[COORD_BITS-1]}}, h_left_q};
  assign hy_e = {{(EW-COORD_BITS){h_top_q[COORD_BITS-1]}}, h_top_q};
  assign rw_e = {{(EW-SPAN_W){1'b0}}, rw_q};
  assign rh_e = {{(EW-SPAN_W){1'b0}}, rh_q};
  assign hw_e = {{(EW-SPAN_W){1'b0}}, h_sx_q};
  assign hh_e = {{(EW-SPAN_W){1'b0}}, h_sy_q};

  assign ea_x = rx_e + rw_e;
  assign eb_x = hx_e + hw_e;
  assign ea_y = ry_e + rh_e;
  assign eb_y = hy_e + hh_e;
  assign dx   = px_e - hx_e;
  assign dy   = py_e - hy_e;
  assign in_ptr_s1 = !dx[EW-1] && (dx < hw_e) && !dy[EW-1] && (dy < hh_e);

  always_ff @(posedge clk_i) begin
    lo_x_q   <= (rx_e > hx_e) ? rx_e : hx_e;
    hi_x_q   <= (ea_x < eb_x) ? ea_x : eb_x;
    lo_y_q   <= (ry_e > hy_e) ? ry_e : hy_e;
    hi_y_q   <= (ea_y < eb_y) ? ea_y : eb_y;
    ptr1_q   <= in_ptr_s1;
    s1_idx_q <= s0_idx_q;
  end

  // Stage 2: overlap lengths, clamped at zero.
  logic signed [EW-1:0] len_x, len_y;
  logic [SPAN_W-1:0]    ov_x_q, ov_y_q;
  logic                 ptr2_q;
  logic [IDX_W-1:0]     s2_idx_q;

  assign len_x = hi_x_q - lo_x_q;
  assign len_y = hi_y_q - lo_y_q;

  always_ff @(posedge clk_i) begin
    ov_x_q   <= (hi_x_q > lo_x_q) ? len_x[SPAN_W-1:0] : '0;
    ov_y_q   <= (hi_y_q > lo_y_q) ? len_y[SPAN_W-1:0] : '0;
    ptr2_q   <= ptr1_q;
    s2_idx_q <= s1_idx_q;
  end

  // Stage 3: overlap area, plus the rectangle's own area.
  logic [AREA_W-1:0] area_q, full_q;
  logic              ptr3_q;
  logic [IDX_W-1:0]  s3_idx_q;

  always_ff @(posedge clk_i) begin
    area_q   <= AREA_W'(ov_x_q) * AREA_W'(ov_y_q);
    full_q   <= AREA_W'(rw_q) * AREA_W'(rh_q);
    ptr3_q   <= ptr2_q;
    s3_idx_q <= s2_idx_q;
  end

  // Stage 4: running sum, best head and first head under the pointer.
  logic [TOT_W-1:0]  total_q;
  logic [AREA_W-1:0] best_q;
  logic [IDX_W-1:0]  best_idx_q, ptr_idx_q;
  logic              found_q, multi_q, ptr_found_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      total_q     <= '0;
      best_q      <= '0;
      best_idx_q  <= '0;
      ptr_idx_q   <= '0;
      found_q     <= 1'b0;
      multi_q     <= 1'b0;
      ptr_found_q <= 1'b0;
    end else if (v3_q) begin
      total_q <= total_q + TOT_W'(area_q);
      if (area_q > best_q) begin
        multi_q    <= multi_q | found_q;
        best_q     <= area_q;
        best_idx_q <= s3_idx_q;
        found_q    <= 1'b1;
      end
      if (ptr3_q && !ptr_found_q) begin
        ptr_found_q <= 1'b1;
        ptr_idx_q   <= s3_idx_q;
      end
    end
  end

  // Result selection into the output register.
  logic [IDX_W+CHOSEN_W-1:0] best_wide, ptr_wide;
  logic [CHOSEN_W-1:0]       chosen_d, chosen_q;
  logic                      dead_q, partial_q, mult_out_q;

  assign best_wide = {{CHOSEN_W{1'b0}}, best_idx_q};
  assign ptr_wide  = {{CHOSEN_W{1'b0}}, ptr_idx_q};

  always_comb begin
    priority if (screen_q) begin
      chosen_d = primary_q;
    end else if (found_q) begin
      chosen_d = best_wide[CHOSEN_W-1:0];
    end else if (pv_q && ptr_found_q) begin
      chosen_d = ptr_wide[CHOSEN_W-1:0];
    end else begin
      chosen_d = primary_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      chosen_q   <= chosen_d;
      dead_q     <= !found_q;
      partial_q  <= found_q && (total_q != TOT_W'(full_q));
      mult_out_q <= multi_q && !screen_q;
    end
  end

  assign chosen_head_o   = chosen_q;
  assign dead_flag_o     = dead_q;
  assign partial_flag_o  = partial_q;
  assign multiple_flag_o = mult_out_q;

endmodule

[hdl/rect_head_placement_classifier.sv]
// Top level of the rectangle head placement classifier.
`timescale 1ns / 1ps

// Classifies a rectangle against a table of display-head rectangles.
// Input channel (in_valid_i / in_stall_o): one beat per item. A load beat
// (opcode 0) writes one head table entry without starting a walk;
// it returns nothing. A classify beat (opcode 1) returns exactly one beat
// on the output channel (out_valid_o / out_stall_i) with the chosen head
// and the dead, partial and multiple flags.
// A classify walks N heads, one table read per cycle, where N is the
// configured head count clamped to MAX_HEADS, or 1 when it is 0 or 1 (the
// full screen is then tested). The walk feeds a four-stage read, overlap
// and area pipeline and an accumulator; the controller then drains the
// pipeline and registers the result, and only after that is the next
// item accepted.
// The input is stalled while a classify is in flight. A finished result
// sits in the output register while the receiver stalls; the next item is
// still accepted, and only its own result waits for the register to free.
// Configuration (cfg_valid_i / cfg_ready_o) is always ready and must be
// written while the block is idle. Reset clears the handshake state and
// loads the screen registers with 1920 by 1080, primary head 0 and head
// count 0; the head table holds nothing until loaded.
module rect_head_placement_classifier #(
  parameter int unsigned MAX_HEADS  = 8,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [rhpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rhpc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic [rhpc_pkg::HIDX_IN_W-1:0]      head_index_i,
  input  logic signed [COORD_BITS-1:0]        rect_x_i,
  input  logic signed [COORD_BITS-1:0]        rect_y_i,
  input  logic [rhpc_pkg::SPAN_W-1:0]         rect_width_i,
  input  logic [rhpc_pkg::SPAN_W-1:0]         rect_height_i,
  input  logic signed [COORD_BITS-1:0]        pointer_x_i,
  input  logic signed [COORD_BITS-1:0]        pointer_y_i,
  input  logic                                pointer_valid_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [rhpc_pkg::CHOSEN_W-1:0]       chosen_head_o,
  output logic                                dead_flag_o,
  output logic                                partial_flag_o,
  output logic                                multiple_flag_o
);
  import rhpc_pkg::*;

  rhpc_cmd_t    cmd;
  rhpc_status_t status;

  // Register writes never wait.
  assign cfg_ready_o = 1'b1;

  rhpc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .opcode_i    (opcode_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rhpc_dp #(
    .MAX_HEADS  (MAX_HEADS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_valid_i & cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .head_index_i    (head_index_i),
    .rect_x_i        (rect_x_i),
    .rect_y_i        (rect_y_i),
    .rect_width_i    (rect_width_i),
    .rect_height_i   (rect_height_i),
    .pointer_x_i     (pointer_x_i),
    .pointer_y_i     (pointer_y_i),
    .pointer_valid_i (pointer_valid_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .chosen_head_o   (chosen_head_o),
    .dead_flag_o     (dead_flag_o),
    .partial_flag_o  (partial_flag_o),
    .multiple_flag_o (multiple_flag_o)
  );

endmodule

[dv/rhpc_placement_checker.sv]
// Scoreboard for the head placement classifier: tracks registers and table, predicts and checks.
`timescale 1ns / 1ps

module rhpc_placement_checker #(
  parameter int unsigned MAX_HEADS  = 8,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  input  logic                                cfg_ready_i,
  input  logic [rhpc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [rhpc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  input  logic                                in_stall_i,
  input  logic                                opcode_i,
  input  logic [rhpc_pkg::HIDX_IN_W-1:0]      head_index_i,
  input  logic signed [COORD_BITS-1:0]        rect_x_i,
  input  logic signed [COORD_BITS-1:0]        rect_y_i,
  input  logic [rhpc_pkg::SPAN_W-1:0]         rect_width_i,
  input  logic [rhpc_pkg::SPAN_W-1:0]         rect_height_i,
  input  logic signed [COORD_BITS-1:0]        pointer_x_i,
  input  logic signed [COORD_BITS-1:0]        pointer_y_i,
  input  logic                                pointer_valid_i,
  input  logic                                out_valid_i,
  input  logic                                out_stall_i,
  input  logic [rhpc_pkg::CHOSEN_W-1:0]       chosen_head_i,
  input  logic                                dead_flag_i,
  input  logic                                partial_flag_i,
  input  logic                                multiple_flag_i,
  output int                                  fail_count_o,
  output int                                  pending_o,
  output int                                  result_count_o
);
  import rhpc_pkg::*;

  typedef struct packed {
    logic [CHOSEN_W-1:0] head;
    logic                dead;
    logic                partial;
    logic                multiple;
  } placement_t;

  // Shadow copy of the registers and the head table.
  logic [SPAN_W-1:0]            screen_w;
  logic [SPAN_W-1:0]            screen_h;
  logic [PRIM_W-1:0]            primary;
  logic [HCNT_W-1:0]            head_cnt;
  logic signed [COORD_BITS-1:0] tbl_left [MAX_HEADS];
  logic signed [COORD_BITS-1:0] tbl_top  [MAX_HEADS];
  logic [SPAN_W-1:0]            tbl_w    [MAX_HEADS];
  logic [SPAN_W-1:0]            tbl_h    [MAX_HEADS];

  placement_t placement_q[$];
  int         report_cnt;

  // Length of the overlap of two half-open intervals, zero when disjoint.
  function automatic longint overlap_len(input longint a0, input longint alen,
                                         input longint b0, input longint blen);
    longint lo;
    longint hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = ((a0 + alen) < (b0 + blen)) ? (a0 + alen) : (b0 + blen);
    return (hi > lo) ? (hi - lo) : 0;
  endfunction

  // Expected placement of one rectangle against the current table and registers.
  function automatic placement_t place_rect(input logic signed [COORD_BITS-1:0] rx,
                                            input logic signed [COORD_BITS-1:0] ry,
                                            input logic [SPAN_W-1:0] rw,
                                            input logic [SPAN_W-1:0] rh,
                                            input logic signed [COORD_BITS-1:0] px,
                                            input logic signed [COORD_BITS-1:0] py,
                                            input logic pv);
    placement_t res;
    longint     full;
    longint     area;
    longint     best;
    longint     total;
    longint     dx;
    longint     dy;
    int         n;
    int         i;
    bit         found;
    bit         located;
    res   = '0;
    full  = longint'(rw) * longint'(rh);
    n     = (head_cnt > MAX_HEADS) ? MAX_HEADS : int'(head_cnt);
    best  = 0;
    total = 0;
    found = 1'b0;
    if (n <= 1) begin
      // Single head or none: test against the whole screen.
      area = overlap_len(rx, rw, 0, screen_w) * overlap_len(ry, rh, 0, screen_h);
      res.head = primary;
      if (area == 0) begin
        res.dead = 1'b1;
      end else if (area != full) begin
        res.partial = 1'b1;
      end
    end else begin
      // Walk the heads in order; only a strictly larger area wins.
      for (i = 0; i < n; i++) begin
        area = overlap_len(rx, rw, tbl_left[i], tbl_w[i]) *
               overlap_len(ry, rh, tbl_top[i], tbl_h[i]);
        total += area;
        if (area > best) begin
          if (found) res.multiple = 1'b1;
          best     = area;
          res.head = i[CHOSEN_W-1:0];
          found    = 1'b1;
        end
      end
      if (!found) begin
        // Dead space: fall back to the first head holding the pointer.
        res.dead = 1'b1;
        res.head = primary;
        located  = 1'b0;
        if (pv) begin
          for (i = 0; i < n; i++) begin
            dx = longint'(px) - longint'(tbl_left[i]);
            dy = longint'(py) - longint'(tbl_top[i]);
            if (!located && dx >= 0 && dx < tbl_w[i] && dy >= 0 && dy < tbl_h[i]) begin
              res.head = i[CHOSEN_W-1:0];
              located  = 1'b1;
            end
          end
        end
      end else if (total != full) begin
        res.partial = 1'b1;
      end
    end
    return res;
  endfunction

  // Watch all three channels; results are checked before new beats are queued.
  always @(posedge clk_i or negedge rst_ni) begin
    placement_t got;
    placement_t want;
    if (!rst_ni) begin
      screen_w   = SCREEN_W_RST;
      screen_h   = SCREEN_H_RST;
      primary    = PRIMARY_RST;
      head_cnt   = HEAD_CNT_RST;
      placement_q.delete();
      fail_count_o   = 0;
      result_count_o = 0;
      report_cnt     = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        got = {chosen_head_i, dead_flag_i, partial_flag_i, multiple_flag_i};
        result_count_o++;
        if (placement_q.size() == 0) begin
          fail_count_o++;
          if (report_cnt < 40) begin
            report_cnt++;
            $display("%0t: result beat with none expected (head %0d d%0b p%0b m%0b)",
                     $time, got.head, got.dead, got.partial, got.multiple);
          end
        end else begin
          want = placement_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (report_cnt < 40) begin
              report_cnt++;
              if (got.head !== want.head)
                $display("%0t: chosen_head expected %0d got %0d", $time, want.head, got.head);
              if (got.dead !== want.dead)
                $display("%0t: dead_flag expected %0b got %0b", $time, want.dead, got.dead);
              if (got.partial !== want.partial)
                $display("%0t: partial_flag expected %0b got %0b", $time, want.partial,
                         got.partial);
              if (got.multiple !== want.multiple)
                $display("%0t: multiple_flag expected %0b got %0b", $time, want.multiple,
                         got.multiple);
            end
          end
        end
      end

      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CFG_SCREEN_WIDTH:  screen_w = cfg_data_i[SPAN_W-1:0];
          CFG_SCREEN_HEIGHT: screen_h = cfg_data_i[SPAN_W-1:0];
          CFG_PRIMARY_HEAD:  primary  = cfg_data_i[PRIM_W-1:0];
          CFG_HEAD_COUNT:    head_cnt = cfg_data_i[HCNT_W-1:0];
          default: ;
        endcase
      end

      if (in_valid_i && !in_stall_i) begin
        if (opcode_i == OP_LOAD) begin
          if (head_index_i < MAX_HEADS) begin
            tbl_left[head_index_i] = rect_x_i;
            tbl_top[head_index_i]  = rect_y_i;
            tbl_w[head_index_i]    = rect_width_i;
            tbl_h[head_index_i]    = rect_height_i;
          end
        end else begin
          placement_q.push_back(place_rect(rect_x_i, rect_y_i, rect_width_i, rect_height_i,
                                           pointer_x_i, pointer_y_i, pointer_valid_i));
        end
      end
    end
    pending_o = placement_q.size();
  end

endmodule

[dv/rect_head_placement_classifier_tb.sv]
// Testbench top for the head placement classifier: stimulus, idling and the verdict.
`timescale 1ns / 1ps

module rect_head_placement_classifier_tb;
  import rhpc_pkg::*;

  logic                    clk;
  logic                    rst_n       = 1'b0;
  logic                    cfg_valid   = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index   = '0;
  logic [CFG_DATA_W-1:0]   cfg_data    = '0;
  logic                    in_valid    = 1'b0;
  logic                    in_stall;
  logic                    opcode      = 1'b0;
  logic [HIDX_IN_W-1:0]    head_index  = '0;
  logic signed [15:0]      rect_x      = '0;
  logic signed [15:0]      rect_y      = '0;
  logic [SPAN_W-1:0]       rect_width  = '0;
  logic [SPAN_W-1:0]       rect_height = '0;
  logic signed [15:0]      pointer_x   = '0;
  logic signed [15:0]      pointer_y   = '0;
  logic                    pointer_valid = 1'b0;
  logic                    out_valid;
  logic                    out_stall   = 1'b0;
  logic [CHOSEN_W-1:0]     chosen_head;
  logic                    dead_flag;
  logic                    partial_flag;
  logic                    multiple_flag;

  int fail_count;
  int pending;
  int result_count;

  // Idling controls shared with the receiver process.
  int send_pct  = 0;
  int recv_pct  = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int n_loads      = 0;
  int n_classify   = 0;
  int n_cfg_writes = 0;

  rect_head_placement_classifier dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .opcode_i        (opcode),
    .head_index_i    (head_index),
    .rect_x_i        (rect_x),
    .rect_y_i        (rect_y),
    .rect_width_i    (rect_width),
    .rect_height_i   (rect_height),
    .pointer_x_i     (pointer_x),
    .pointer_y_i     (pointer_y),
    .pointer_valid_i (pointer_valid),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .chosen_head_o   (chosen_head),
    .dead_flag_o     (dead_flag),
    .partial_flag_o  (partial_flag),
    .multiple_flag_o (multiple_flag)
  );

  rhpc_placement_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .opcode_i        (opcode),
    .head_index_i    (head_index),
    .rect_x_i        (rect_x),
    .rect_y_i        (rect_y),
    .rect_width_i    (rect_width),
    .rect_height_i   (rect_height),
    .pointer_x_i     (pointer_x),
    .pointer_y_i     (pointer_y),
    .pointer_valid_i (pointer_valid),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .chosen_head_i   (chosen_head),
    .dead_flag_i     (dead_flag),
    .partial_flag_i  (partial_flag),
    .multiple_flag_i (multiple_flag),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .result_count_o  (result_count)
  );

  // 12 ns clock.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Receiver: random stalls, plus a long hold-off whenever one is requested.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = 400;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #7200000;
    $display("Timeout: the block stopped moving beats");
    $display("== FAIL ==");
    $finish;
  end

  // One register write; the valid drops again at the following falling edge.
  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_cfg_writes++;
  endtask

  // Wait until every expected result has come, then let the pipeline empty.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // Offer one input beat after a random gap and wait for it to be taken.
  task automatic send_item(input opcode_e op, input logic [HIDX_IN_W-1:0] idx,
                           input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic [SPAN_W-1:0] w, input logic [SPAN_W-1:0] h,
                           input logic signed [15:0] px, input logic signed [15:0] py,
                           input logic pv);
    while ($urandom_range(99) < send_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    opcode        <= op;
    head_index    <= idx;
    rect_x        <= x;
    rect_y        <= y;
    rect_width    <= w;
    rect_height   <= h;
    pointer_x     <= px;
    pointer_y     <= py;
    pointer_valid <= pv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OP_LOAD) n_loads++;
    else n_classify++;
  endtask

  task automatic load_head(input logic [HIDX_IN_W-1:0] idx,
                           input logic signed [15:0] x, input logic signed [15:0] y,
                           input logic [SPAN_W-1:0] w, input logic [SPAN_W-1:0] h);
    send_item(OP_LOAD, idx, x, y, w, h, 16'($urandom), 16'($urandom), 1'($urandom));
  endtask

  task automatic classify(input logic signed [15:0] x, input logic signed [15:0] y,
                          input logic [SPAN_W-1:0] w, input logic [SPAN_W-1:0] h,
                          input logic signed [15:0] px, input logic signed [15:0] py,
                          input logic pv);
    send_item(OP_CLASSIFY, 3'($urandom), x, y, w, h, px, py, pv);
  endtask

  // Signed coordinate drawn from a window around the usual desktop area.
  function automatic logic signed [15:0] near_coord(input int lo, input int hi);
    int v;
    v = lo + int'($urandom_range(hi - lo));
    return 16'(v);
  endfunction

  // One random beat: mostly plausible layouts and rectangles, some raw noise.
  task automatic random_item();
    bit noise;
    bit is_load;
    noise   = ($urandom_range(99) < 15);
    is_load = ($urandom_range(99) < 25);
    if (noise) begin
      send_item(is_load ? OP_LOAD : OP_CLASSIFY, 3'($urandom), 16'($urandom), 16'($urandom),
                15'($urandom), 15'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
    end else if (is_load) begin
      if ($urandom_range(99) < 30) begin
        // Heads on a regular grid, as a real monitor arrangement would be.
        load_head(3'($urandom), 16'(int'($urandom_range(3)) * 1920 - 1920),
                  16'(int'($urandom_range(2)) * 1080 - 1080), 15'd1920, 15'd1080);
      end else begin
        load_head(3'($urandom), near_coord(-2000, 6000), near_coord(-1500, 4500),
                  15'($urandom_range(3000)), 15'($urandom_range(2500)));
      end
    end else begin
      classify(near_coord(-2500, 7000), near_coord(-2000, 5000),
               15'($urandom_range(2500)), 15'($urandom_range(2000)),
               near_coord(-2500, 7000), near_coord(-2000, 5000),
               $urandom_range(99) < 75);
    end
  endtask

  // Register settings for the random phases: width, height, primary head, head count.
  int unsigned ph_w     [8] = '{1920, 32767, 1, 3840, 1920, 2560, 800, 32767};
  int unsigned ph_h     [8] = '{1080, 32767, 1, 2160, 1080, 1440, 600, 1};
  int unsigned ph_prim  [8] = '{0, 7, 3, 5, 1, 6, 4, 2};
  int unsigned ph_count [8] = '{0, 1, 1, 4, 2, 8, 12, 15};
  int          ph_send  [4] = '{0, 83, 0, 27};
  int          ph_recv  [4] = '{0, 0, 83, 27};

  initial begin
    int p;
    int k;
    int per_phase;
    per_phase = 216;

    // Reset.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: fill every table entry, including the coordinate extremes.
    load_head(3'd0, 16'sd0, 16'sd0, 15'd1920, 15'd1080);
    load_head(3'd1, 16'sd1920, 16'sd0, 15'd1920, 15'd1080);
    load_head(3'd2, 16'sd0, 16'sd1080, 15'd1920, 15'd1080);
    load_head(3'd3, 16'sd1920, 16'sd1080, 15'd1920, 15'd1080);
    load_head(3'd4, -16'sd32768, -16'sd32768, 15'd32767, 15'd32767);
    load_head(3'd5, 16'sd32767, 16'sd32767, 15'd32767, 15'd32767);
    load_head(3'd6, 16'sd1000, 16'sd500, 15'd1000, 15'd1000);
    load_head(3'd7, 16'sd0, 16'sd0, 15'd0, 15'd0);

    // Reset registers, no heads: inside, partly off screen, off screen, empty rectangle.
    classify(16'sd100, 16'sd100, 15'd200, 15'd200, 16'sd0, 16'sd0, 1'b1);
    classify(16'sd1800, 16'sd1000, 15'd400, 15'd400, 16'sd0, 16'sd0, 1'b1);
    classify(-16'sd500, -16'sd500, 15'd100, 15'd100, 16'sd0, 16'sd0, 1'b0);
    classify(16'sd10, 16'sd10, 15'd0, 15'd5, 16'sd0, 16'sd0, 1'b1);

    // Four tiled heads.
    settle();
    write_reg(CFG_HEAD_COUNT, 15'd4);
    write_reg(CFG_PRIMARY_HEAD, 15'd2);
    // Even split keeps the first head; a later larger share replaces it.
    classify(16'sd1820, 16'sd100, 15'd200, 15'd100, 16'sd0, 16'sd0, 1'b0);
    classify(16'sd1900, 16'sd100, 15'd200, 15'd100, 16'sd0, 16'sd0, 1'b0);
    // Dead space: pointer on a head corner, pointer unknown, past the edge, on a head's last pixel.
    classify(-16'sd1000, -16'sd1000, 15'd10, 15'd10, 16'sd1920, 16'sd1080, 1'b1);
    classify(-16'sd1000, -16'sd1000, 15'd10, 15'd10, 16'sd2000, 16'sd1500, 1'b0);
    classify(-16'sd1000, -16'sd1000, 15'd10, 15'd10, 16'sd3840, 16'sd1500, 1'b1);
    classify(-16'sd1000, -16'sd1000, 15'd10, 15'd10, 16'sd3839, 16'sd2159, 1'b1);
    // Partly off the left edge of the layout.
    classify(-16'sd100, 16'sd0, 15'd200, 15'd100, 16'sd0, 16'sd0, 1'b1);

    // Count above the table size, with the largest rectangles.
    settle();
    write_reg(CFG_HEAD_COUNT, 15'd15);
    classify(-16'sd32768, -16'sd32768, 15'd32767, 15'd32767, -16'sd32768, -16'sd32768, 1'b1);
    classify(16'sd32767, 16'sd32767, 15'd32767, 15'd32767, 16'sd32767, 16'sd32767, 1'b1);

    // Random phases, each with its own registers and idling mix.
    for (p = 0; p < 8; p++) begin
      settle();
      send_pct = ph_send[p % 4];
      recv_pct = ph_recv[p % 4];
      write_reg(CFG_SCREEN_WIDTH, 15'(ph_w[p]));
      write_reg(CFG_SCREEN_HEIGHT, 15'(ph_h[p]));
      write_reg(CFG_PRIMARY_HEAD, {12'($urandom), 3'(ph_prim[p])});
      write_reg(CFG_HEAD_COUNT, {11'($urandom), 4'(ph_count[p])});
      // The receiver holds off for a long stretch while beats keep coming.
      if (p % 4 == 0) begin
        @(posedge clk);
        hold_reqs++;
      end
      for (k = 0; k < per_phase; k++) begin
        // Halfway through, the sender waits until the block has drained.
        if (k == per_phase / 2) begin
          @(negedge clk);
          in_valid <= 1'b0;
          while (pending != 0) @(negedge clk);
        end
        random_item();
      end
    end

    settle();
    $display("Sent %0d beats: %0d table loads and %0d classifications; %0d results checked.",
             n_loads + n_classify, n_loads, n_classify, result_count);
    $display("Used %0d register writes: head counts 0 to 15, screens from 1x1 to full size.",
             n_cfg_writes);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/rhpc_pkg.sv
hdl/rhpc_ctrl.sv
hdl/rhpc_dp.sv
hdl/rect_head_placement_classifier.sv
dv/rhpc_placement_checker.sv
dv/rect_head_placement_classifier_tb.sv
